>>> hw/rtl/ztrb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ztrb_pkg
// Shared types and constants for the zigzag tiered residual bit packer.
// ----------------------------------------------------------------------------
package ztrb_pkg;

   // default scratch limit in bytes
   localparam int SCRATCH_BYTES_DEFAULT = 256;

   // configuration register layout
   localparam int         BASE_WIDTH_W     = 6;
   localparam logic [5:0] BASE_WIDTH_RESET = 6'd3;

   // action codes
   localparam logic ACTION_ENCODE = 1'b0;
   localparam logic ACTION_FLUSH  = 1'b1;

   // input item
   typedef struct packed {
      logic               action;
      logic signed [63:0] residual;
   } req_payload_type;

   // result item
   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
      logic       dropped;
   } rsp_payload_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;
      logic code;
      logic align;
      logic emit;
      logic finish;
   } dp_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic count_zero;
   } dp_status_type;

endpackage

>>> hw/rtl/ztrb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ztrb_ctrl
// Sequencer: accept an item, build its code, align it behind the pending
// bits, stream out the bytes, then commit the writer state.
// ----------------------------------------------------------------------------
module ztrb_ctrl
   import ztrb_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_CODE  = 2'd1;
   localparam logic [1:0] ST_ALIGN = 2'd2;
   localparam logic [1:0] ST_EMIT  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_CODE;
         ST_CODE:  state_in = ST_ALIGN;
         ST_ALIGN: state_in = ST_EMIT;
         ST_EMIT:  if (status.count_zero) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // commands
   assign req_ready  = (state_ff == ST_IDLE);
   assign cmd.load   = req_ready && req_valid;
   assign cmd.code   = (state_ff == ST_CODE);
   assign cmd.align  = (state_ff == ST_ALIGN);
   assign cmd.emit   = (state_ff == ST_EMIT);
   assign cmd.finish = (state_ff == ST_EMIT) && status.count_zero;

   // sequencing checks
   a_code_to_align: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CODE) |=> (state_ff == ST_ALIGN))
      else $error("code step not followed by align");
   a_load_to_code: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (state_ff == ST_CODE))
      else $error("accepted item did not start coding");

endmodule

>>> hw/rtl/ztrb_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ztrb_datapath
// Code builder, alignment shifter, byte output register and writer state.
// ----------------------------------------------------------------------------
module ztrb_datapath
   import ztrb_pkg::*;
#(
   parameter int SCRATCH_BYTES = SCRATCH_BYTES_DEFAULT
)
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wr_en,
   input  logic [BASE_WIDTH_W-1:0] csr_wr_data,
   input  req_payload_type         req_payload,
   input  dp_cmd_type              cmd,
   output dp_status_type           status,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output rsp_payload_type         rsp_payload
);

   localparam int         BW_W   = $clog2(SCRATCH_BYTES + 1);
   localparam int         CODE_W = 68;
   localparam int         BUF_W  = 80;
   localparam logic [5:0] K_MAX  = 6'd32;

   // configuration
   logic [BASE_WIDTH_W-1:0] base_width_ff;

   // captured item
   logic        action_ff;
   logic [63:0] residual_ff;

   // code stage
   logic [CODE_W-1:0] code_ff, code_in;
   logic [6:0]        len_ff, len_in;

   // alignment and emission
   logic [BUF_W-1:0] buf_ff, buf_in;
   logic [3:0]       count_ff, count_in;
   logic [2:0]       rem_ff, rem_in;

   // writer state, pending bits kept left aligned
   logic [6:0]      pend_ff, pend_in;
   logic [2:0]      pc_ff, pc_in;
   logic [BW_W-1:0] bw_ff, bw_in;

   // output register
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_ff, rsp_in;

   logic            slot_free;
   logic            emit_fire;
   logic            at_limit;
   logic [5:0]      k;
   logic [6:0]      k7;
   logic [63:0]     zz;
   logic            fit0, fit1, fit2, fit3;
   logic [6:0]      total;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         base_width_ff <= BASE_WIDTH_RESET;
      end else if (csr_wr_en) begin
         base_width_ff <= csr_wr_data;
      end
   end

   // capture the accepted item
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff   <= req_payload.action;
         residual_ff <= req_payload.residual;
      end
   end

   // zigzag map and tier choice
   assign k    = (base_width_ff > K_MAX) ? K_MAX : base_width_ff;
   assign k7   = {1'b0, k};
   assign zz   = {residual_ff[62:0], 1'b0} ^ {64{residual_ff[63]}};
   assign fit0 = (zz >> k7) == 64'd0;
   assign fit1 = (zz >> (k7 + 7'd2)) == 64'd0;
   assign fit2 = (zz >> (k7 + 7'd5)) == 64'd0;
   assign fit3 = (zz >> (k7 + 7'd10)) == 64'd0;

   always_comb begin
      if (fit0) begin
         code_in = {4'b0, zz};
         len_in  = k7 + 7'd1;
      end else if (fit1) begin
         code_in = {4'b0, zz} | (CODE_W'(2'b10) << (k7 + 7'd2));
         len_in  = k7 + 7'd4;
      end else if (fit2) begin
         code_in = {4'b0, zz} | (CODE_W'(3'b110) << (k7 + 7'd5));
         len_in  = k7 + 7'd8;
      end else if (fit3) begin
         code_in = {4'b0, zz} | (CODE_W'(4'b1110) << (k7 + 7'd10));
         len_in  = k7 + 7'd14;
      end else begin
         // escape: all-ones prefix then the raw residual
         code_in = {4'b1111, residual_ff};
         len_in  = 7'(CODE_W);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.code) begin
         code_ff <= code_in;
         len_ff  <= len_in;
      end
   end

   // place the code right behind the pending bits, left aligned
   assign total = {4'b0, pc_ff} + len_ff;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign emit_fire = cmd.emit && slot_free && (count_ff != 4'd0);
   assign at_limit  = (bw_ff >= BW_W'(SCRATCH_BYTES));

   always_comb begin
      buf_in   = buf_ff;
      count_in = count_ff;
      rem_in   = rem_ff;
      if (cmd.align) begin
         if (action_ff == ACTION_FLUSH) begin
            buf_in   = {pend_ff, {(BUF_W-7){1'b0}}};
            count_in = (pc_ff != 3'd0) ? 4'd1 : 4'd0;
            rem_in   = 3'd0;
         end else begin
            buf_in   = ({{(BUF_W-CODE_W){1'b0}}, code_ff} << (7'(BUF_W) - total))
                       | {pend_ff, {(BUF_W-7){1'b0}}};
            count_in = total[6:3];
            rem_in   = total[2:0];
         end
      end else if (emit_fire) begin
         buf_in   = buf_ff << 8;
         count_in = count_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 4'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
      rem_ff <= rem_in;
   end

   // writer state update
   always_comb begin
      pend_in = pend_ff;
      pc_in   = pc_ff;
      bw_in   = bw_ff;
      if (emit_fire && !at_limit) begin
         bw_in = bw_ff + BW_W'(1);
      end
      if (cmd.finish) begin
         if (action_ff == ACTION_FLUSH) begin
            pend_in = 7'd0;
            pc_in   = 3'd0;
            bw_in   = '0;
         end else begin
            pend_in = buf_ff[BUF_W-1 -: 7];
            pc_in   = rem_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 7'd0;
         pc_ff   <= 3'd0;
         bw_ff   <= '0;
      end else begin
         pend_ff <= pend_in;
         pc_ff   <= pc_in;
         bw_ff   <= bw_in;
      end
   end

   // byte output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (emit_fire) begin
         rsp_valid_in       = 1'b1;
         rsp_in.out_byte    = at_limit ? 8'd0 : buf_ff[BUF_W-1 -: 8];
         rsp_in.dropped     = at_limit;
         rsp_in.last_of_run = (count_ff == 4'd1);
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_payload       = rsp_ff;
   assign status.count_zero = (count_ff == 4'd0);

   // datapath checks
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 4'd9)
      else $error("byte count above nine");
   a_drop_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.dropped) |-> (rsp_ff.out_byte == 8'd0))
      else $error("dropped item carries data");
   a_scratch_bound: assert property (@(posedge clock) disable iff (reset)
      bw_ff <= BW_W'(SCRATCH_BYTES))
      else $error("byte counter past scratch limit");

endmodule

>>> hw/rtl/zigzag_tiered_residual_bitpacker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zigzag_tiered_residual_bitpacker
// Zigzag maps signed residuals, codes them with a tiered prefix code and
// packs the bits MSB first into bytes, one result item per byte.
// ----------------------------------------------------------------------------
// One item at a time: the next item is taken only once the current one has
// been coded, aligned and emitted as the n (0 to 9) bytes it
// produces; the bytes leave through a one-entry output register at one per
// cycle while the consumer keeps up, and that register sets the pace. An
// encode item yields up to 9 bytes (escape code), a flush at most 1. No
// clearing pass follows reset. base_width may be written only while idle.
module zigzag_tiered_residual_bitpacker
   import ztrb_pkg::*;
#(
   parameter int SCRATCH_BYTES = SCRATCH_BYTES_DEFAULT
)
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wr_en,
   input  logic [BASE_WIDTH_W-1:0] csr_wr_data,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  req_payload_type         req_payload,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output rsp_payload_type         rsp_payload
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // sequencer
   ztrb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // coding and packing datapath
   ztrb_datapath #(
      .SCRATCH_BYTES (SCRATCH_BYTES)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the zigzag tiered residual bit packer. A directed
// table covers tier boundaries, escapes, flushes and the base width
// extremes. Random phases at several base widths follow, then one long
// escape run that fills the scratch limit. A bit-level packer shadow predicts
// all but the typed bytes, and each output byte is compared field by field.
// ----------------------------------------------------------------------------
module tb_top;
   import ztrb_pkg::*;

   localparam int HALF_PERIOD   = 2;
   localparam int RESET_CYCLES  = 9;
   localparam int DRAIN_CYCLES  = 16;
   localparam int IDLE_PCT      = 13;
   localparam int RANDOM_PHASES = 5;
   localparam int PHASE_ITEMS   = 10;
   localparam int ESCAPE_RUN    = 34;
   localparam int TIER_K_MAX    = 32;

   // kinds of rows in the directed table
   typedef enum logic [1:0] {
      ROW_PREDICT,
      ROW_NO_BYTE,
      ROW_ONE_BYTE,
      ROW_BASE_WIDTH
   } row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic         action;
      logic [63:0]  value;
      logic [7:0]   exp_byte;
   } stim_row_type;

   // directed table, base width 3 out of reset
   localparam int NUM_ROWS = 28;
   localparam stim_row_type DIRECTED_ROWS [NUM_ROWS] = '{
      '{ROW_NO_BYTE,    ACTION_ENCODE, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00},
      '{ROW_ONE_BYTE,   ACTION_ENCODE, 64'h0000_0000_0000_0003, 8'h16},
      '{ROW_NO_BYTE,    ACTION_FLUSH,  64'h0000_0000_0000_0000, 8'h00},
      '{ROW_NO_BYTE,    ACTION_ENCODE, 64'h0000_0000_0000_0000, 8'h00},
      '{ROW_ONE_BYTE,   ACTION_FLUSH,  64'hFFFF_FFFF_FFFF_FFFF, 8'h00},
      '{ROW_PREDICT,    ACTION_ENCODE, 64'h0000_0000_0000_0004, 8'h00},
      '{ROW_PREDICT,    ACTION_ENCODE, 64'hFFFF_FFFF_FFFF_FFF0, 8'h00},
      '{ROW_PREDICT,    ACTION_ENCODE, 64'h0000_0000_0000_0010, 8'h00},
      '{ROW_PREDICT,    ACTION_ENCODE, 64'hFFFF_FFFF_FFFF_F000, 8'h00},
      '{ROW_PREDICT,    ACTION_ENCODE, 64'h0000_0000_0000_1000, 8'h00},
      '{ROW_PREDICT,    ACTION_ENCODE, 64'h8000_0000_0000_0000, 8'h00},
      '{ROW_PREDICT,    ACTION_ENCODE, 64'h7FFF_FFFF_FFFF_FFFF, 8'h00},
      '{ROW_PREDICT,    ACTION_FLUSH,  64'h0000_0000_0000_0000, 8'h00},
      '{ROW_BASE_WIDTH, ACTION_ENCODE, 64'd0,                   8'h00},
      '{ROW_PREDICT,    ACTION_ENCODE, 64'h0000_0000_0000_0000, 8'h00},
      '{ROW_PREDICT,    ACTION_ENCODE, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00},
      '{ROW_PREDICT,    ACTION_ENCODE, 64'h0000_0000_0000_0001, 8'h00},
      '{ROW_PREDICT,    ACTION_ENCODE, 64'h0000_0000_0000_0002, 8'h00},
      '{ROW_PREDICT,    ACTION_FLUSH,  64'h0000_0000_0000_0000, 8'h00},
      '{ROW_BASE_WIDTH, ACTION_ENCODE, 64'd32,                  8'h00},
      '{ROW_PREDICT,    ACTION_ENCODE, 64'h0000_0000_7FFF_FFFF, 8'h00},
      '{ROW_PREDICT,    ACTION_ENCODE, 64'hFFFF_FE00_0000_0000, 8'h00},
      '{ROW_PREDICT,    ACTION_ENCODE, 64'h0000_0200_0000_0000, 8'h00},
      '{ROW_PREDICT,    ACTION_FLUSH,  64'h0000_0000_0000_0000, 8'h00},
      '{ROW_BASE_WIDTH, ACTION_ENCODE, 64'd63,                  8'h00},
      '{ROW_PREDICT,    ACTION_ENCODE, 64'hFFFF_FFFF_8000_0000, 8'h00},
      '{ROW_PREDICT,    ACTION_ENCODE, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00},
      '{ROW_PREDICT,    ACTION_FLUSH,  64'h0000_0000_0000_0000, 8'h00}
   };

   // block ports
   logic                    clock       = 1'b0;
   logic                    reset       = 1'b1;
   logic                    csr_wr_en   = 1'b0;
   logic [BASE_WIDTH_W-1:0] csr_wr_data = '0;
   logic                    req_valid   = 1'b0;
   logic                    req_ready;
   req_payload_type         req_payload = '0;
   logic                    rsp_valid;
   logic                    rsp_ready   = 1'b0;
   rsp_payload_type         rsp_payload;

   // no random idling on either side while set
   logic no_idle = 1'b0;

   // shadow of the packer state
   logic [BASE_WIDTH_W-1:0] base_width_cfg = BASE_WIDTH_RESET;
   logic [7:0]              pack_bits      = '0;
   int unsigned             pack_count     = 0;
   int unsigned             scratch_used   = 0;

   rsp_payload_type item_bytes [$];
   rsp_payload_type expected_bytes [$];
   int error_count = 0;

   zigzag_tiered_residual_bitpacker u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always #HALF_PERIOD clock = ~clock;

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      error_count++;
   endtask

   // one completed byte, zeroed and flagged once the scratch area is full
   task automatic emit_byte(input logic [7:0] data);
      rsp_payload_type r;
      r.last_of_run = 1'b0;
      if (scratch_used < SCRATCH_BYTES_DEFAULT) begin
         r.out_byte = data;
         r.dropped  = 1'b0;
         scratch_used++;
      end else begin
         r.out_byte = 8'h00;
         r.dropped  = 1'b1;
      end
      item_bytes.push_back(r);
   endtask

   // shift in the low nbits of val, msb first
   task automatic append_bits(input logic [63:0] val, input int unsigned nbits);
      for (int i = int'(nbits) - 1; i >= 0; i--) begin
         pack_bits = {pack_bits[6:0], val[i]};
         pack_count++;
         if (pack_count == 8) begin
            emit_byte(pack_bits);
            pack_bits  = '0;
            pack_count = 0;
         end
      end
   endtask

   // bytes caused by one item, left in item_bytes
   task automatic pack_item(input req_payload_type item);
      logic [63:0]     raw;
      logic [63:0]     zz;
      int unsigned     k;
      rsp_payload_type tail;
      item_bytes.delete();
      if (item.action == ACTION_FLUSH) begin
         if (pack_count > 0)
            emit_byte(pack_bits << (8 - pack_count));
         pack_bits    = '0;
         pack_count   = 0;
         scratch_used = 0;
      end else begin
         raw = item.residual;
         zz  = (raw << 1) ^ {64{raw[63]}};
         k   = (base_width_cfg > TIER_K_MAX) ? TIER_K_MAX : base_width_cfg;
         if (zz < (64'd1 << k))
            append_bits(zz, k + 1);
         else if (zz < (64'd1 << (k + 2)))
            append_bits((64'h2 << (k + 2)) | zz, k + 4);
         else if (zz < (64'd1 << (k + 5)))
            append_bits((64'h6 << (k + 5)) | zz, k + 8);
         else if (zz < (64'd1 << (k + 10)))
            append_bits((64'hE << (k + 10)) | zz, k + 14);
         else begin
            // escape: raw residual, high word first
            append_bits(64'hF, 4);
            append_bits(raw, 64);
         end
      end
      if (item_bytes.size() > 0) begin
         tail = item_bytes.pop_back();
         tail.last_of_run = 1'b1;
         item_bytes.push_back(tail);
      end
   endtask

   // present one item from a falling edge, return at the falling edge after
   // acceptance with valid still high
   task automatic send_item(input req_payload_type item, input row_kind_type kind,
                            input logic [7:0] typed_byte);
      rsp_payload_type r;
      while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_payload <= item;
      req_valid   <= 1'b1;
      do @(posedge clock); while (!req_ready);
      pack_item(item);
      case (kind)
         ROW_NO_BYTE: ;
         ROW_ONE_BYTE: begin
            r.out_byte    = typed_byte;
            r.last_of_run = 1'b1;
            r.dropped     = 1'b0;
            expected_bytes.push_back(r);
         end
         default: begin
            foreach (item_bytes[i])
               expected_bytes.push_back(item_bytes[i]);
         end
      endcase
      @(negedge clock);
   endtask

   // hold off until every byte is in and the block has settled
   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_bytes.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_base_width(input logic [BASE_WIDTH_W-1:0] width);
      drain_results();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= width;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      base_width_cfg = width;
   endtask

   // result side stalls
   always @(negedge clock)
      rsp_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);

   // compare each accepted byte with the oldest expectation
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_bytes.size() == 0) begin
            report_mismatch($sformatf("unexpected byte %02h", rsp_payload.out_byte));
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_payload.out_byte !== want.out_byte)
               report_mismatch($sformatf("out_byte %02h, want %02h",
                                         rsp_payload.out_byte, want.out_byte));
            if (rsp_payload.last_of_run !== want.last_of_run)
               report_mismatch($sformatf("last_of_run %b, want %b",
                                         rsp_payload.last_of_run, want.last_of_run));
            if (rsp_payload.dropped !== want.dropped)
               report_mismatch($sformatf("dropped %b, want %b",
                                         rsp_payload.dropped, want.dropped));
         end
      end
   end

   // stimulus
   initial begin
      stim_row_type    row;
      req_payload_type item;
      logic [63:0]     raw;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table
      for (int r = 0; r < NUM_ROWS; r++) begin
         row = DIRECTED_ROWS[r];
         if (row.kind == ROW_BASE_WIDTH) begin
            write_base_width(row.value[BASE_WIDTH_W-1:0]);
         end else begin
            item.action   = row.action;
            item.residual = row.value;
            send_item(item, row.kind, row.exp_byte);
         end
      end

      // random phases, base widths 0, 32 and 63 first, then random ones
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0:       write_base_width('0);
            1:       write_base_width(BASE_WIDTH_W'(TIER_K_MAX));
            2:       write_base_width('1);
            default: write_base_width(BASE_WIDTH_W'($urandom_range(0, 63)));
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 7) == 0) begin
               item.action   = ACTION_FLUSH;
               item.residual = {$urandom, $urandom};
            end else begin
               raw           = {$urandom, $urandom} >> $urandom_range(0, 63);
               item.action   = ACTION_ENCODE;
               item.residual = $urandom_range(0, 1) ? -raw : raw;
            end
            send_item(item, ROW_PREDICT, 8'h00);
         end
      end

      // escape run past the scratch limit with no idling, then a padded flush
      write_base_width(BASE_WIDTH_W'($urandom_range(0, 63)));
      no_idle = 1'b1;
      for (int n = 0; n < ESCAPE_RUN; n++) begin
         raw           = {$urandom, $urandom};
         raw[62]       = ~raw[63];
         item.action   = ACTION_ENCODE;
         item.residual = raw;
         send_item(item, ROW_PREDICT, 8'h00);
      end
      item.action   = ACTION_ENCODE;
      item.residual = '0;
      send_item(item, ROW_PREDICT, 8'h00);
      item.action = ACTION_FLUSH;
      send_item(item, ROW_PREDICT, 8'h00);
      no_idle = 1'b0;

      drain_results();
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // run limit
   initial begin
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

>>> sim.f
hw/rtl/ztrb_pkg.sv
hw/rtl/ztrb_ctrl.sv
hw/rtl/ztrb_datapath.sv
hw/rtl/zigzag_tiered_residual_bitpacker.sv
test/tb_top.sv
